/* rtl/core/tpsm_pkg.sv */
package tpsm_pkg;

   localparam int CoordWidth = 16;
   localparam int EntryWidth = 32;
   localparam int FracShift  = 16;
   localparam int NumEntries = 6;

   localparam int EdgeWidth = CoordWidth + 1;
   localparam int ProdWidth = 2 * EdgeWidth;
   localparam int DotWidth  = ProdWidth + 1;
   localparam int MagWidth  = DotWidth;
   localparam int NumWidth  = MagWidth + FracShift + 1;
   localparam int DenWidth  = MagWidth + 1;
   localparam int NumHiWidth = NumWidth - EntryWidth;

   localparam int BitsPerStage = 2;
   localparam int DivStages    = EntryWidth / BitsPerStage;
   localparam int DivLatency   = DivStages + 1;
   localparam int Latency      = DivLatency + 6;

   localparam int PairA [NumEntries] = '{0, 0, 0, 1, 1, 2};
   localparam int PairB [NumEntries] = '{0, 1, 2, 1, 2, 2};

   typedef struct packed {
      logic                  valid;
      logic                  degen;
      logic [NumEntries-1:0] neg;
   } flag_type;

   typedef struct packed {
      logic [DenWidth-1:0] rem;
      logic                bit_q;
   } step_type;

   function automatic step_type div_step(input logic [DenWidth-1:0] rem,
                                         input logic nb,
                                         input logic [DenWidth-1:0] den);
      logic [DenWidth:0] part;
      step_type          r;
      part = {rem, nb};
      if (part >= {1'b0, den}) begin
         r.rem   = DenWidth'(part - {1'b0, den});
         r.bit_q = 1'b1;
      end else begin
         r.rem   = part[DenWidth-1:0];
         r.bit_q = 1'b0;
      end
      return r;
   endfunction

endpackage

/* rtl/core/tpsm_div.sv */
module tpsm_div (
   input  logic                               clock,
   input  logic [tpsm_pkg::NumWidth-1:0]      div_num,
   input  logic [tpsm_pkg::DenWidth-1:0]      div_den,
   output logic [tpsm_pkg::EntryWidth-1:0]    div_quot,
   output logic                               div_ovf
);
   import tpsm_pkg::*;

   logic [DenWidth-1:0]   den_ff  [0:DivStages-1];
   logic [DenWidth-1:0]   rem_ff  [0:DivStages-1];
   logic [EntryWidth-1:0] low_ff  [0:DivStages-1];
   logic [EntryWidth-1:0] quot_ff [0:DivStages];
   logic                  ovf_ff  [0:DivStages];
   logic [NumHiWidth-1:0] num_hi;

   assign num_hi = div_num[NumWidth-1:EntryWidth];

   always_ff @(posedge clock) begin
      den_ff[0]  <= div_den;
      rem_ff[0]  <= DenWidth'(num_hi);
      low_ff[0]  <= div_num[EntryWidth-1:0];
      quot_ff[0] <= '0;
      ovf_ff[0]  <= DenWidth'(num_hi) >= div_den;
   end

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      step_type sa;
      step_type sb;
      assign sa = div_step(rem_ff[s], low_ff[s][EntryWidth-1], den_ff[s]);
      assign sb = div_step(sa.rem, low_ff[s][EntryWidth-2], den_ff[s]);
      always_ff @(posedge clock) begin
         quot_ff[s+1] <= {quot_ff[s][EntryWidth-3:0], sa.bit_q, sb.bit_q};
         ovf_ff[s+1]  <= ovf_ff[s];
      end
      if (s < DivStages - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            den_ff[s+1] <= den_ff[s];
            rem_ff[s+1] <= sb.rem;
            low_ff[s+1] <= low_ff[s] << BitsPerStage;
         end
      end
   end

   assign div_quot = quot_ff[DivStages];
   assign div_ovf  = ovf_ff[DivStages];

endmodule

/* rtl/core/triangle_p1_stiffness_matrix_top.sv */
// P1 triangle stiffness matrix.
// Input: a transfer takes place at a clock edge with start high and busy
// low; it carries the three vertices as signed Q7.8 coordinates.
// Output: rsp_valid is high for exactly one cycle per input transfer and
// marks the six distinct entries of the symmetric 3x3 matrix in signed
// Q15.16, each rounded to nearest (ties away from zero) and saturated,
// with rsp_saturated set when any entry clipped and rsp_degenerate set
// (entries zero) for a zero-area triangle.
// Path: a start transfer passes the input, edge, product, sum, numerator,
// divider and output registers. Throughput: one triangle per cycle while
// busy is low; the block is fully pipelined, six restoring dividers at
// two quotient bits per stage setting most of the depth.
// Reset: synchronous, active high; clears every valid bit in flight, and
// busy is high only while reset is applied and for the cycle after.
// The receiver cannot stall: results are dropped on the ports for one
// cycle and must be taken then.
module triangle_p1_stiffness_matrix_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [tpsm_pkg::CoordWidth-1:0]  req_first_x,
   input  logic signed [tpsm_pkg::CoordWidth-1:0]  req_first_y,
   input  logic signed [tpsm_pkg::CoordWidth-1:0]  req_second_x,
   input  logic signed [tpsm_pkg::CoordWidth-1:0]  req_second_y,
   input  logic signed [tpsm_pkg::CoordWidth-1:0]  req_third_x,
   input  logic signed [tpsm_pkg::CoordWidth-1:0]  req_third_y,
   output logic                                    rsp_valid,
   output logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_00,
   output logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_01,
   output logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_02,
   output logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_11,
   output logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_12,
   output logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_22,
   output logic                                    rsp_degenerate,
   output logic                                    rsp_saturated
);
   import tpsm_pkg::*;

   localparam logic [EntryWidth-1:0] MaxPos = {1'b0, {(EntryWidth-1){1'b1}}};
   localparam logic [EntryWidth-1:0] MinNeg = {1'b1, {(EntryWidth-1){1'b0}}};

   logic                         busy_ff;
   logic                         accept;
   logic [3:0]                   valid_ff;
   logic signed [CoordWidth-1:0] vx_ff [3];
   logic signed [CoordWidth-1:0] vy_ff [3];
   logic signed [EdgeWidth-1:0]  ex_ff [3];
   logic signed [EdgeWidth-1:0]  ey_ff [3];
   logic signed [ProdWidth-1:0]  pxx_ff [NumEntries];
   logic signed [ProdWidth-1:0]  pyy_ff [NumEntries];
   logic signed [ProdWidth-1:0]  pa_ff;
   logic signed [ProdWidth-1:0]  pb_ff;
   logic signed [DotWidth-1:0]   dot_ff [NumEntries];
   logic signed [DotWidth-1:0]   area_ff;
   logic [MagWidth-1:0]          amag;
   logic [MagWidth-1:0]          dmag [NumEntries];
   logic [NumWidth-1:0]          num_ff [NumEntries];
   logic [DenWidth-1:0]          den_ff;
   flag_type                     flag_in;
   flag_type                     flag_ff [0:DivLatency];
   logic [EntryWidth-1:0]        quot [NumEntries];
   logic [NumEntries-1:0]        ovf;
   logic [EntryWidth-1:0]        entry_in [NumEntries];
   logic [NumEntries-1:0]        sat_in;
   logic [EntryWidth-1:0]        entry_ff [NumEntries];
   logic                         valid_out_ff;
   logic                         degen_ff;
   logic                         sat_ff;

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= {valid_ff[2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      vx_ff[0] <= req_first_x;
      vy_ff[0] <= req_first_y;
      vx_ff[1] <= req_second_x;
      vy_ff[1] <= req_second_y;
      vx_ff[2] <= req_third_x;
      vy_ff[2] <= req_third_y;
      for (int i = 0; i < 3; i++) begin
         ex_ff[i] <= EdgeWidth'(vx_ff[(i+1)%3]) - EdgeWidth'(vx_ff[(i+2)%3]);
         ey_ff[i] <= EdgeWidth'(vy_ff[(i+1)%3]) - EdgeWidth'(vy_ff[(i+2)%3]);
      end
      for (int k = 0; k < NumEntries; k++) begin
         pxx_ff[k] <= ProdWidth'(ex_ff[PairA[k]]) * ProdWidth'(ex_ff[PairB[k]]);
         pyy_ff[k] <= ProdWidth'(ey_ff[PairA[k]]) * ProdWidth'(ey_ff[PairB[k]]);
         dot_ff[k] <= DotWidth'(pxx_ff[k]) + DotWidth'(pyy_ff[k]);
         num_ff[k] <= (NumWidth'(dmag[k]) << FracShift) + NumWidth'(amag);
      end
      pa_ff   <= ProdWidth'(ex_ff[1]) * ProdWidth'(ey_ff[2]);
      pb_ff   <= ProdWidth'(ex_ff[2]) * ProdWidth'(ey_ff[1]);
      area_ff <= DotWidth'(pa_ff) - DotWidth'(pb_ff);
      den_ff  <= {DenWidth'(amag)} << 1;
   end

   always_comb begin
      amag = area_ff[DotWidth-1] ? MagWidth'(-area_ff) : MagWidth'(area_ff);
      for (int k = 0; k < NumEntries; k++) begin
         dmag[k]       = dot_ff[k][DotWidth-1] ? MagWidth'(-dot_ff[k])
                                               : MagWidth'(dot_ff[k]);
         flag_in.neg[k] = dot_ff[k][DotWidth-1] ^ area_ff[DotWidth-1];
      end
      flag_in.valid = valid_ff[3];
      flag_in.degen = (area_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DivLatency; i++) begin
            flag_ff[i] <= '0;
         end
      end else begin
         flag_ff[0] <= flag_in;
         for (int i = 1; i <= DivLatency; i++) begin
            flag_ff[i] <= flag_ff[i-1];
         end
      end
   end

   for (genvar k = 0; k < NumEntries; k++) begin : g_div
      tpsm_div u_div (
         .clock    (clock),
         .div_num  (num_ff[k]),
         .div_den  (den_ff),
         .div_quot (quot[k]),
         .div_ovf  (ovf[k])
      );
   end

   always_comb begin
      for (int k = 0; k < NumEntries; k++) begin
         if (flag_ff[DivLatency].degen) begin
            sat_in[k]   = 1'b0;
            entry_in[k] = '0;
         end else if (flag_ff[DivLatency].neg[k]) begin
            sat_in[k]   = ovf[k] | (quot[k][EntryWidth-1] & (|quot[k][EntryWidth-2:0]));
            entry_in[k] = sat_in[k] ? MinNeg : -quot[k];
         end else begin
            sat_in[k]   = ovf[k] | quot[k][EntryWidth-1];
            entry_in[k] = sat_in[k] ? MaxPos : quot[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else begin
         valid_out_ff <= flag_ff[DivLatency].valid;
      end
      for (int k = 0; k < NumEntries; k++) begin
         entry_ff[k] <= entry_in[k];
      end
      degen_ff <= flag_ff[DivLatency].degen;
      sat_ff   <= |sat_in;
   end

   assign rsp_valid      = valid_out_ff;
   assign rsp_entry_00   = entry_ff[0];
   assign rsp_entry_01   = entry_ff[1];
   assign rsp_entry_02   = entry_ff[2];
   assign rsp_entry_11   = entry_ff[3];
   assign rsp_entry_12   = entry_ff[4];
   assign rsp_entry_22   = entry_ff[5];
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

endmodule

/* rtl/core/tpsm_chk.sv */
module tpsm_chk (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    start,
   input logic                                    busy,
   input logic                                    rsp_valid,
   input logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_00,
   input logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_01,
   input logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_02,
   input logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_11,
   input logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_12,
   input logic signed [tpsm_pkg::EntryWidth-1:0]  rsp_entry_22,
   input logic                                    rsp_degenerate,
   input logic                                    rsp_saturated
);
   import tpsm_pkg::*;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result transfer without matching start transfer");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result transfer right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_saturated && rsp_entry_00 == 0 &&
      rsp_entry_01 == 0 && rsp_entry_02 == 0 && rsp_entry_11 == 0 &&
      rsp_entry_12 == 0 && rsp_entry_22 == 0)
      else $error("degenerate triangle with non-zero entries");

   a_diag_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_00 < 0 |-> rsp_entry_11 <= 0 && rsp_entry_22 <= 0)
      else $error("diagonal entries disagree in sign");

endmodule

bind triangle_p1_stiffness_matrix_top tpsm_chk u_tpsm_chk (.*);

/* bench/triangle_p1_stiffness_matrix_top_test.sv */
`timescale 1ns / 1ps

module triangle_p1_stiffness_matrix_top_test;
   import tpsm_pkg::*;

   typedef struct {
      logic signed [CoordWidth-1:0] ax, ay, bx, by, cx, cy;
   } triangle_type;

   typedef struct {
      logic signed [EntryWidth-1:0] k [NumEntries];
      logic degen;
      logic sat;
   } stiffness_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CoordWidth-1:0] req_first_x = '0, req_first_y = '0;
   logic signed [CoordWidth-1:0] req_second_x = '0, req_second_y = '0;
   logic signed [CoordWidth-1:0] req_third_x = '0, req_third_y = '0;
   logic rsp_valid, rsp_degenerate, rsp_saturated;
   logic signed [EntryWidth-1:0] rsp_entry_00, rsp_entry_01, rsp_entry_02;
   logic signed [EntryWidth-1:0] rsp_entry_11, rsp_entry_12, rsp_entry_22;

   triangle_type  pending_tris [$];
   stiffness_type expected_mats [$];
   int            errors = 0;
   bit            hold_for_drain = 1'b0;
   int            burst_left = 0;
   int            gap_left = 0;
   triangle_type  cur_tri;

   triangle_p1_stiffness_matrix_top uut (.*);

   always #2 clock = ~clock;

   function automatic logic signed [EntryWidth-1:0] scaled_entry(
         input logic signed [127:0] dot, input logic signed [127:0] area,
         inout logic sat);
      logic [127:0] mdot, marea, q;
      logic         neg;
      logic [127:0] lim;
      mdot  = dot < 0 ? -dot : dot;
      marea = area < 0 ? -area : area;
      q     = ((mdot << FracShift) + marea) / (marea << 1);
      neg   = (dot < 0) != (area < 0);
      lim   = 128'd1 << (EntryWidth - 1);
      if (!neg) begin
         if (q > lim - 1) begin
            sat = 1'b1;
            return EntryWidth'(lim - 1);
         end
         return EntryWidth'(q);
      end
      if (q > lim) begin
         sat = 1'b1;
         return EntryWidth'(-lim);
      end
      return EntryWidth'(-q);
   endfunction

   function automatic stiffness_type stiffness_of(input triangle_type t);
      logic signed [127:0] ex [3], ey [3], area, dot;
      stiffness_type m;
      m.sat   = 1'b0;
      m.degen = 1'b0;
      ex[0] = 128'(t.bx) - 128'(t.cx);  ey[0] = 128'(t.by) - 128'(t.cy);
      ex[1] = 128'(t.cx) - 128'(t.ax);  ey[1] = 128'(t.cy) - 128'(t.ay);
      ex[2] = 128'(t.ax) - 128'(t.bx);  ey[2] = 128'(t.ay) - 128'(t.by);
      area = ex[1] * ey[2] - ex[2] * ey[1];
      for (int n = 0; n < NumEntries; n++) begin
         if (area == 0) begin
            m.k[n] = '0;
         end else begin
            dot = ey[PairA[n]] * ey[PairB[n]] + ex[PairA[n]] * ex[PairB[n]];
            m.k[n] = scaled_entry(dot, area, m.sat);
         end
      end
      m.degen = (area == 0);
      return m;
   endfunction

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic add_tri(input int ax, ay, bx, by, cx, cy);
      triangle_type t;
      t.ax = CoordWidth'(ax); t.ay = CoordWidth'(ay);
      t.bx = CoordWidth'(bx); t.by = CoordWidth'(by);
      t.cx = CoordWidth'(cx); t.cy = CoordWidth'(cy);
      pending_tris = {pending_tris, t};
   endtask

   function automatic int rand_coord(input int span);
      if (span >= 32768) return $urandom_range(0, 65535) - 32768;
      return $urandom_range(0, 2 * span) - span;
   endfunction

   always @(posedge clock) begin
      if (start && !busy && !reset) begin
         expected_mats = {expected_mats, stiffness_of(cur_tri)};
      end
      if (reset || (start && busy)) begin
      end else if (hold_for_drain || pending_tris.size() == 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else begin
         cur_tri = pending_tris.pop_front();
         req_first_x <= cur_tri.ax;  req_first_y <= cur_tri.ay;
         req_second_x <= cur_tri.bx; req_second_y <= cur_tri.by;
         req_third_x <= cur_tri.cx;  req_third_y <= cur_tri.cy;
         start <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      stiffness_type want;
      logic signed [EntryWidth-1:0] got [NumEntries];
      if (!reset && rsp_valid) begin
         got = '{rsp_entry_00, rsp_entry_01, rsp_entry_02,
                 rsp_entry_11, rsp_entry_12, rsp_entry_22};
         if (expected_mats.size() == 0) begin
            report("unexpected result", 64'd0, 64'd0);
         end else begin
            want = expected_mats.pop_front();
            for (int n = 0; n < NumEntries; n++)
               if (got[n] !== want.k[n])
                  report($sformatf("entry %0d", n), 64'(got[n]), 64'(want.k[n]));
            if (rsp_degenerate !== want.degen)
               report("degenerate", 64'(rsp_degenerate), 64'(want.degen));
            if (rsp_saturated !== want.sat)
               report("saturated", 64'(rsp_saturated), 64'(want.sat));
         end
      end
   end

   initial begin
      int span;
      int x, y, dx, dy;
      add_tri(0, 0, 256, 0, 0, 256);
      add_tri(0, 0, 0, 256, 256, 0);
      add_tri(-32768, -32768, 32767, -32768, -32768, 32767);
      add_tri(32767, 32767, -32768, 32767, 32767, -32768);
      add_tri(0, 0, 1, 0, 0, 1);
      add_tri(0, 0, 1, 0, 0, 32767);
      add_tri(0, 0, 32767, 0, 0, 1);
      add_tri(-32768, 0, 32767, 0, 0, 1);
      add_tri(5, 5, 5, 5, 5, 5);
      add_tri(0, 0, 100, 100, 200, 200);
      add_tri(-32768, -32768, 32767, 32767, 0, 0);
      add_tri(1, 1, 2, 2, 3, 4);
      add_tri(0, 0, 3, 0, 1, 2);
      add_tri(-1, -1, -1, -1, -1, -1);
      add_tri(0, -32768, 32767, 32767, -32768, 32767);
      add_tri(10, 0, 0, 0, 0, 7);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_tris.size() == 0);
      for (int i = 0; i < 550; i++) begin
         case ($urandom_range(0, 5))
            0: span = 32768;
            1: span = 4;
            2: span = 300;
            default: span = $urandom_range(1, 32768);
         endcase
         if ($urandom_range(0, 15) == 0) begin
            x  = rand_coord(span);
            y  = rand_coord(span);
            dx = rand_coord(64);
            dy = rand_coord(64);
            add_tri(x, y, x + dx, y + dy, x - dx, y - dy);
         end else begin
            add_tri(rand_coord(span), rand_coord(span), rand_coord(span),
                    rand_coord(span), rand_coord(span), rand_coord(span));
         end
         if (i == 250) begin
            wait (pending_tris.size() == 0);
            @(posedge clock);
            hold_for_drain = 1'b1;
            @(posedge clock);
            wait (expected_mats.size() == 0);
            @(posedge clock);
            hold_for_drain = 1'b0;
         end
      end
      wait (pending_tris.size() == 0);
      @(posedge clock);
      @(posedge clock);
      wait (expected_mats.size() == 0);
      repeat (Latency + 10) @(posedge clock);
      if (errors == 0 && expected_mats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #400us;
      $display("Regression FAIL");
      $finish;
   end

endmodule
